// ===== hw/rtl/i2c_eeprom_page_transfer_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// I2C EEPROM page transfer sequencer: assertion macros
// Shared property forms used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_PAGE_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_EEPROM_PAGE_TRANSFER_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CEE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM page transfer sequencer package
// Types, codes and helper functions shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

   localparam int PAGE_BITS    = 3;
   localparam int BUFFER_DEPTH = 256;
   localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int MAX_RESULTS  = 4;
   localparam int SLOT_W       = 2;

   localparam logic [7:0] PAGE_MASK  = 8'((1 << PAGE_BITS) - 1);
   localparam logic [7:0] CTRL_WRITE = 8'hA0;
   localparam logic [7:0] CTRL_READ  = 8'hA1;
   localparam logic [7:0] DEV_MASK   = 8'h0E;

   typedef enum logic [2:0] {
      OP_LOAD       = 3'd0,
      OP_READ       = 3'd1,
      OP_WRITE      = 3'd2,
      OP_SEND_REPLY = 3'd3,
      OP_RECV_REPLY = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ACT_START = 3'd0,
      ACT_SEND  = 3'd1,
      ACT_RACK  = 3'd2,
      ACT_RNACK = 3'd3,
      ACT_STOP  = 3'd4,
      ACT_DATA  = 3'd5,
      ACT_DONE  = 3'd6
   } act_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_CTRL_W = 4'd1,
      PH_ADDR   = 4'd2,
      PH_CTRL_R = 4'd3,
      PH_DATA_W = 4'd4,
      PH_RECV   = 4'd5
   } phase_type;

   // what one accepted beat does to the transfer
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_START  = 3'd1,
      EV_ADDR   = 3'd2,
      EV_DATA   = 3'd3,
      EV_RSTART = 3'd4,
      EV_ASK    = 3'd5,
      EV_END    = 3'd6
   } ev_type;

   typedef struct packed {
      act_type    action;
      logic [7:0] bus_byte;
      logic [7:0] read_index;
      logic       use_buf;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [SLOT_W-1:0]            last;
   } group_type;

   function automatic result_type mk_result(act_type act, logic [7:0] byte_val,
                                            logic [7:0] idx, logic use_buf);
      result_type r;
      r.action     = act;
      r.bus_byte   = byte_val;
      r.read_index = idx;
      r.use_buf    = use_buf;
      return r;
   endfunction

   function automatic logic [7:0] ctrl_byte(logic [2:0] dev, logic rd);
      logic [7:0] dev_bits;
      dev_bits = ({5'd0, dev} << 1) & DEV_MASK;
      return dev_bits | (rd ? CTRL_READ : CTRL_WRITE);
   endfunction

   // position modulo the buffer depth (a power of two: keep the low bits)
   function automatic logic [BUF_AW-1:0] buf_index(logic [7:0] pos);
      return BUF_AW'(32'(pos) % BUFFER_DEPTH);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2cee_if.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM page transfer sequencer channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cee_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [2:0] device;
   logic [7:0] address;
   logic [7:0] count;
   logic [7:0] data_byte;
   logic [7:0] load_index;
   logic       acked;

   modport source (output valid, opcode, device, address, count, data_byte,
                   load_index, acked, input ready);
   modport sink (input valid, opcode, device, address, count, data_byte,
                 load_index, acked, output ready);
endinterface

interface i2cee_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] bus_byte;
   logic [7:0] read_index;
   logic       last;

   modport source (output valid, action, bus_byte, read_index, last, input ready);
   modport sink (input valid, action, bus_byte, read_index, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2cee_out_stage.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer result stage
// Holds the result group of one request beat and sends it one beat a cycle while rsp_chan is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_page_transfer_sequencer_macros.svh"

module i2cee_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  i2cee_pkg::group_type group,
   input  wire  [7:0]           rd_data,
   output logic                 free,
   i2cee_rsp_if.source          rsp_chan
);
   import i2cee_pkg::*;

   group_type         grp_ff;
   logic              valid_ff;
   logic [SLOT_W-1:0] slot_ff;
   result_type        cur;
   logic              beat;
   logic              at_last;

   assign cur     = grp_ff.res[slot_ff];
   assign at_last = (slot_ff == grp_ff.last);
   assign beat    = rsp_chan.valid && rsp_chan.ready;
   assign free    = !valid_ff || (rsp_chan.ready && at_last);

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.action     = cur.action;
   assign rsp_chan.bus_byte   = cur.use_buf ? rd_data : cur.bus_byte;
   assign rsp_chan.read_index = cur.read_index;
   assign rsp_chan.last       = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         slot_ff  <= '0;
      end else if (beat) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
      end
   end

   `I2CEE_ASSERT_IMP(a_load_when_free, clock, reset, load, free, "group loaded over a pending group")
   `I2CEE_ASSERT_IMP(a_slot_range, clock, reset, valid_ff, slot_ff <= grp_ff.last, "slot past group end")
   `I2CEE_ASSERT_NEXT(a_slot_advance, clock, reset, beat && !at_last && !load, slot_ff == $past(slot_ff) + 2'd1, "slot did not advance")

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_eeprom_page_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM page transfer sequencer
// Splits multi-byte EEPROM reads and writes into page chunks and issues
// the bus primitives for each chunk.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries load beats (write data into the byte buffer), read and
//  write requests, and the replies of the bus engine. rsp_chan carries the
//  bus primitives, delivered read bytes and the done marker; last flags the
//  final result beat caused by one request beat.
//  The first result of a beat is offered in the cycle after it is accepted.
//  A beat causing k results (0 to 4) holds req_chan while the result register
//  drains over the single rsp_chan port; while rsp_chan is ready, beats with
//  at most one result are taken every cycle. Write data is read from the
//  buffer memory into a register at acceptance, at the same edge as the
//  result register is loaded.
//  Reset clears the transfer state to idle; buffer contents are kept and are
//  undefined until loaded. When rsp_chan stalls, the result register holds
//  and req_chan is taken again only as the last pending result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_page_transfer_sequencer_macros.svh"

module i2c_eeprom_page_transfer_sequencer (
   input  wire          clock,
   input  wire          reset,
   i2cee_req_if.sink    req_chan,
   i2cee_rsp_if.source  rsp_chan
);
   import i2cee_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       is_write_ff, is_write_in;
   logic [2:0] dev_ff, dev_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] size_ff, size_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] rd_ff;

   logic [7:0] wbuf_mem [BUFFER_DEPTH];

   logic       req_fire;
   logic       free;
   ev_type     ev;
   logic       with_data;
   logic       step;
   logic       rewind;
   logic       from_req;
   logic       load_ok;

   logic [7:0] left_dec;
   logic [7:0] left_mid;
   logic [7:0] pos_mid;
   logic [8:0] end_sum;
   logic [2:0] end_dev;
   logic [7:0] end_rem;
   logic       end_more;
   logic [2:0] base_dev;
   logic [7:0] base_addr;
   logic [7:0] base_rem;
   logic [8:0] space;
   logic [7:0] new_size;

   group_type  grp_next;
   logic       grp_has;

   assign req_chan.ready = free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign load_ok  = (req_chan.opcode == OP_LOAD) &&
                     ({1'b0, req_chan.load_index} < 9'(BUFFER_DEPTH));
   assign left_dec = left_ff - 8'd1;
   assign left_mid = step ? left_dec : left_ff;
   assign pos_mid  = step ? (pos_ff + 8'd1) : pos_ff;

   // chunk end: advance address, carry into device, count down
   assign end_sum  = {1'b0, addr_ff} + {1'b0, size_ff};
   assign end_dev  = dev_ff + 3'(end_sum[8]);
   assign end_rem  = rem_ff - size_ff;
   assign end_more = (end_rem != 8'd0);

   always_comb begin
      if (from_req) begin
         base_dev  = req_chan.device;
         base_addr = req_chan.address;
         base_rem  = req_chan.count;
      end else if (ev == EV_START) begin
         base_dev  = dev_ff;
         base_addr = addr_ff;
         base_rem  = rem_ff;
      end else begin
         base_dev  = end_dev;
         base_addr = end_sum[7:0];
         base_rem  = end_rem;
      end
   end

   // room left in the page, capped by what remains
   assign space    = {1'b0, (~base_addr) & PAGE_MASK} + 9'd1;
   assign new_size = ({1'b0, base_rem} < space) ? base_rem : space[7:0];

   // decode the beat against the current phase
   always_comb begin
      ev        = EV_NONE;
      with_data = 1'b0;
      step      = 1'b0;
      rewind    = 1'b0;
      from_req  = 1'b0;
      if ((req_chan.opcode == OP_READ || req_chan.opcode == OP_WRITE) &&
          phase_ff == PH_IDLE) begin
         ev       = EV_START;
         from_req = 1'b1;
      end else if (req_chan.opcode == OP_SEND_REPLY &&
                   (phase_ff == PH_CTRL_W || phase_ff == PH_ADDR ||
                    phase_ff == PH_CTRL_R || phase_ff == PH_DATA_W)) begin
         if (!req_chan.acked) begin
            ev     = EV_START;
            rewind = 1'b1;
         end else begin
            case (phase_ff)
               PH_CTRL_W: begin
                  ev = EV_ADDR;
               end
               PH_ADDR: begin
                  if (!is_write_ff) begin
                     ev = EV_RSTART;
                  end else if (left_ff != 8'd0) begin
                     ev = EV_DATA;
                  end else begin
                     ev = EV_END;
                  end
               end
               PH_CTRL_R: begin
                  ev = (left_ff != 8'd0) ? EV_ASK : EV_END;
               end
               PH_DATA_W: begin
                  step = 1'b1;
                  ev   = (left_dec != 8'd0) ? EV_DATA : EV_END;
               end
               default: begin
                  ev = EV_NONE;
               end
            endcase
         end
      end else if (req_chan.opcode == OP_RECV_REPLY && phase_ff == PH_RECV) begin
         with_data = 1'b1;
         step      = 1'b1;
         ev        = (left_dec != 8'd0) ? EV_ASK : EV_END;
      end
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      is_write_in = is_write_ff;
      dev_in      = dev_ff;
      addr_in     = addr_ff;
      rem_in      = rem_ff;
      size_in     = size_ff;
      left_in     = step ? left_dec : left_ff;
      pos_in      = pos_mid;
      if (from_req) begin
         pos_in      = 8'd0;
         is_write_in = (req_chan.opcode == OP_WRITE);
      end else if (rewind) begin
         // resend the chunk from its first byte
         pos_in = pos_ff - (size_ff - left_ff);
      end
      case (ev)
         EV_START: begin
            dev_in   = base_dev;
            addr_in  = base_addr;
            rem_in   = base_rem;
            size_in  = new_size;
            left_in  = new_size;
            phase_in = PH_CTRL_W;
         end
         EV_ADDR: begin
            phase_in = PH_ADDR;
         end
         EV_DATA: begin
            phase_in = PH_DATA_W;
         end
         EV_RSTART: begin
            phase_in = PH_CTRL_R;
         end
         EV_ASK: begin
            phase_in = PH_RECV;
         end
         EV_END: begin
            dev_in  = end_dev;
            addr_in = end_sum[7:0];
            rem_in  = end_rem;
            if (end_more) begin
               size_in  = new_size;
               left_in  = new_size;
               phase_in = PH_CTRL_W;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // result group of this beat
   always_comb begin
      logic [2:0] n;
      n        = 3'd0;
      grp_next = '0;
      if (with_data) begin
         grp_next.res[n[1:0]] = mk_result(ACT_DATA, req_chan.data_byte, pos_ff, 1'b0);
         n = n + 3'd1;
      end
      case (ev)
         EV_START: begin
            grp_next.res[n[1:0]] = mk_result(ACT_START, 8'd0, 8'd0, 1'b0);
            n = n + 3'd1;
            grp_next.res[n[1:0]] = mk_result(ACT_SEND, ctrl_byte(base_dev, 1'b0),
                                             8'd0, 1'b0);
            n = n + 3'd1;
         end
         EV_ADDR: begin
            grp_next.res[n[1:0]] = mk_result(ACT_SEND, addr_ff, 8'd0, 1'b0);
            n = n + 3'd1;
         end
         EV_DATA: begin
            grp_next.res[n[1:0]] = mk_result(ACT_SEND, 8'd0, 8'd0, 1'b1);
            n = n + 3'd1;
         end
         EV_RSTART: begin
            grp_next.res[n[1:0]] = mk_result(ACT_START, 8'd0, 8'd0, 1'b0);
            n = n + 3'd1;
            grp_next.res[n[1:0]] = mk_result(ACT_SEND, ctrl_byte(dev_ff, 1'b1),
                                             8'd0, 1'b0);
            n = n + 3'd1;
         end
         EV_ASK: begin
            grp_next.res[n[1:0]] = mk_result((left_mid == 8'd1) ? ACT_RNACK : ACT_RACK,
                                             8'd0, 8'd0, 1'b0);
            n = n + 3'd1;
         end
         EV_END: begin
            grp_next.res[n[1:0]] = mk_result(ACT_STOP, 8'd0, 8'd0, 1'b0);
            n = n + 3'd1;
            if (end_more) begin
               grp_next.res[n[1:0]] = mk_result(ACT_START, 8'd0, 8'd0, 1'b0);
               n = n + 3'd1;
               grp_next.res[n[1:0]] = mk_result(ACT_SEND, ctrl_byte(base_dev, 1'b0),
                                                8'd0, 1'b0);
               n = n + 3'd1;
            end else begin
               grp_next.res[n[1:0]] = mk_result(ACT_DONE, 8'd0, 8'd0, 1'b0);
               n = n + 3'd1;
            end
         end
         default: begin
            n = n;
         end
      endcase
      grp_has       = (n != 3'd0);
      grp_next.last = n[1:0] - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         is_write_ff <= 1'b0;
         dev_ff      <= '0;
         addr_ff     <= '0;
         rem_ff      <= '0;
         size_ff     <= '0;
         left_ff     <= '0;
         pos_ff      <= '0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         is_write_ff <= is_write_in;
         dev_ff      <= dev_in;
         addr_ff     <= addr_in;
         rem_ff      <= rem_in;
         size_ff     <= size_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
      end
   end

   // write buffer: load port and data read for the next send beat
   always_ff @(posedge clock) begin
      if (req_fire && load_ok) begin
         wbuf_mem[req_chan.load_index[BUF_AW-1:0]] <= req_chan.data_byte;
      end
      if (req_fire && ev == EV_DATA) begin
         rd_ff <= wbuf_mem[buf_index(pos_mid)];
      end
   end

   i2cee_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire && grp_has),
      .group    (grp_next),
      .rd_data  (rd_ff),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

   `I2CEE_ASSERT_NEXT(a_start_enters_ctrl, clock, reset, req_fire && ev == EV_START, phase_ff == PH_CTRL_W, "chunk start did not enter control phase")
   `I2CEE_ASSERT_IMP(a_idle_no_reply, clock, reset, phase_ff == PH_IDLE, ev == EV_NONE || from_req, "reply acted on while idle")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM page transfer sequencer testbench
// Plays scripted and random EEPROM transfers into the sequencer, with load,
// request and bus reply beats and some noise. Every accepted beat is run
// through a local sequencer model, and each result beat is checked in order
// against the bus primitives that the model predicts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cee_pkg::*;

   localparam logic [2:0] OP_SPARE_MIN = 3'd5;
   localparam int RANDOM_BEATS = 50;
   localparam int TAIL_CYCLES  = 16;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic [2:0] opcode;
      logic [2:0] device;
      logic [7:0] address;
      logic [7:0] count;
      logic [7:0] data_byte;
      logic [7:0] load_index;
      logic       acked;
      bit         drain_first;
   } req_beat_t;

   typedef struct {
      logic [2:0] action;
      logic [7:0] bus_byte;
      logic [7:0] read_index;
      logic       last;
   } bus_op_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cee_req_if req_chan ();
   i2cee_rsp_if rsp_chan ();

   i2c_eeprom_page_transfer_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sequencer model state
   phase_type  xfer_phase;
   logic       wr_xfer;
   logic [2:0] cur_dev;
   logic [7:0] cur_addr;
   logic [7:0] bytes_left;
   logic [7:0] chunk_len;
   logic [7:0] chunk_rem;
   logic [7:0] xfer_pos;
   logic [7:0] wbuf [BUFFER_DEPTH];

   bus_op_t bus_ops_due [$];
   bus_op_t held_op;
   bit      op_held;
   int      ops_made;

   // stimulus planning
   req_beat_t pending_beats [$];
   bit        loaded [BUFFER_DEPTH];
   int        useful_beats;
   bit        pause_next;

   int errors;
   int gap_left;
   int stall_left;
   int hold_left;
   bit hold_armed;
   int due_count;
   int beats_taken;
   int results_taken;
   int beats_sent;
   int beat_total;
   int quiet_from;
   bit quiet;

   task automatic flag_error(input string msg);
      $display("%0t tb: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void emit(act_type act, logic [7:0] byte_val, logic [7:0] idx);
      if (op_held) begin
         bus_ops_due.push_back(held_op);
      end
      held_op.action     = act;
      held_op.bus_byte   = byte_val;
      held_op.read_index = idx;
      held_op.last       = 1'b0;
      op_held = 1'b1;
      ops_made++;
   endfunction

   function automatic logic [7:0] control_byte(logic rd);
      return ({4'd0, cur_dev, 1'b0} & DEV_MASK) | (rd ? CTRL_READ : CTRL_WRITE);
   endfunction

   function automatic void open_chunk();
      int room;
      room = int'(~cur_addr & PAGE_MASK) + 1;
      chunk_len = (room < int'(bytes_left)) ? 8'(room) : bytes_left;
      chunk_rem = chunk_len;
      emit(ACT_START, 8'd0, 8'd0);
      emit(ACT_SEND, control_byte(1'b0), 8'd0);
      xfer_phase = PH_CTRL_W;
   endfunction

   function automatic void close_chunk();
      int total;
      total = int'(cur_addr) + int'(chunk_len);
      emit(ACT_STOP, 8'd0, 8'd0);
      // address ran off the end of the device: move to the next one
      if (total > 255) begin
         cur_dev = cur_dev + 3'd1;
      end
      cur_addr   = 8'(total);
      bytes_left = bytes_left - chunk_len;
      if (bytes_left != 8'd0) begin
         open_chunk();
      end else begin
         emit(ACT_DONE, 8'd0, 8'd0);
         xfer_phase = PH_IDLE;
      end
   endfunction

   function automatic void send_next_byte();
      emit(ACT_SEND, wbuf[int'(xfer_pos) % BUFFER_DEPTH], 8'd0);
      xfer_phase = PH_DATA_W;
   endfunction

   function automatic void ask_byte();
      emit((chunk_rem == 8'd1) ? ACT_RNACK : ACT_RACK, 8'd0, 8'd0);
      xfer_phase = PH_RECV;
   endfunction

   function automatic void seq_reset();
      xfer_phase = PH_IDLE;
      wr_xfer    = 1'b0;
      cur_dev    = 3'd0;
      cur_addr   = 8'd0;
      bytes_left = 8'd0;
      chunk_len  = 8'd0;
      chunk_rem  = 8'd0;
      xfer_pos   = 8'd0;
      op_held    = 1'b0;
      bus_ops_due.delete();
   endfunction

   // advance the model by one beat; queue its bus ops, return how many
   function automatic int sequence_bus_ops(req_beat_t b);
      ops_made = 0;
      case (b.opcode)
         OP_LOAD: begin
            if (int'(b.load_index) < BUFFER_DEPTH) begin
               wbuf[b.load_index] = b.data_byte;
            end
         end
         OP_READ, OP_WRITE: begin
            if (xfer_phase == PH_IDLE) begin
               wr_xfer    = (b.opcode == OP_WRITE);
               cur_dev    = b.device;
               cur_addr   = b.address;
               bytes_left = b.count;
               xfer_pos   = 8'd0;
               open_chunk();
            end
         end
         OP_SEND_REPLY: begin
            if (xfer_phase == PH_CTRL_W || xfer_phase == PH_ADDR ||
                xfer_phase == PH_CTRL_R || xfer_phase == PH_DATA_W) begin
               if (!b.acked) begin
                  // rewind to the chunk start and redo the addressing
                  xfer_pos = xfer_pos - (chunk_len - chunk_rem);
                  open_chunk();
               end else begin
                  case (xfer_phase)
                     PH_CTRL_W: begin
                        emit(ACT_SEND, cur_addr, 8'd0);
                        xfer_phase = PH_ADDR;
                     end
                     PH_ADDR: begin
                        if (wr_xfer) begin
                           if (chunk_rem != 8'd0) send_next_byte();
                           else close_chunk();
                        end else begin
                           emit(ACT_START, 8'd0, 8'd0);
                           emit(ACT_SEND, control_byte(1'b1), 8'd0);
                           xfer_phase = PH_CTRL_R;
                        end
                     end
                     PH_CTRL_R: begin
                        if (chunk_rem != 8'd0) ask_byte();
                        else close_chunk();
                     end
                     default: begin
                        xfer_pos  = xfer_pos + 8'd1;
                        chunk_rem = chunk_rem - 8'd1;
                        if (chunk_rem != 8'd0) send_next_byte();
                        else close_chunk();
                     end
                  endcase
               end
            end
         end
         OP_RECV_REPLY: begin
            if (xfer_phase == PH_RECV) begin
               emit(ACT_DATA, b.data_byte, xfer_pos);
               xfer_pos  = xfer_pos + 8'd1;
               chunk_rem = chunk_rem - 8'd1;
               if (chunk_rem != 8'd0) ask_byte();
               else close_chunk();
            end
         end
         default: ;
      endcase
      if (op_held) begin
         held_op.last = 1'b1;
         bus_ops_due.push_back(held_op);
         op_held = 1'b0;
      end
      return ops_made;
   endfunction

   function automatic req_beat_t rand_beat(logic [2:0] op);
      req_beat_t b;
      b.opcode      = op;
      b.device      = 3'($urandom);
      b.address     = 8'($urandom);
      b.count       = 8'($urandom);
      b.data_byte   = 8'($urandom);
      b.load_index  = 8'($urandom);
      b.acked       = 1'($urandom);
      b.drain_first = 1'b0;
      return b;
   endfunction

   function automatic void push_beat(req_beat_t b);
      int n;
      b.drain_first = pause_next;
      pause_next = 1'b0;
      pending_beats.push_back(b);
      n = sequence_bus_ops(b);
      if (b.opcode == OP_LOAD) begin
         loaded[b.load_index] = 1'b1;
      end
      if (b.opcode == OP_LOAD || n > 0) begin
         useful_beats++;
      end
   endfunction

   function automatic void load_byte(logic [7:0] idx, logic [7:0] val);
      req_beat_t b;
      b = rand_beat(OP_LOAD);
      b.load_index = idx;
      b.data_byte  = val;
      push_beat(b);
   endfunction

   function automatic void answer(bit acked);
      req_beat_t b;
      b = rand_beat((xfer_phase == PH_RECV) ? OP_RECV_REPLY : OP_SEND_REPLY);
      if (xfer_phase != PH_RECV) begin
         b.acked = acked;
      end
      push_beat(b);
   endfunction

   function automatic void issue_request(bit wr, logic [2:0] dev, logic [7:0] addr,
                                         logic [7:0] cnt);
      req_beat_t b;
      // fill every buffer entry the write will fetch
      if (wr) begin
         for (int p = 0; p < int'(cnt); p++) begin
            if (!loaded[p]) load_byte(8'(p), 8'($urandom));
         end
      end
      b = rand_beat(wr ? OP_WRITE : OP_READ);
      b.device  = dev;
      b.address = addr;
      b.count   = cnt;
      push_beat(b);
   endfunction

   function automatic void busy_noise();
      req_beat_t b;
      case ($urandom_range(0, 3))
         0: b = rand_beat(OP_LOAD);
         1: b = rand_beat((xfer_phase == PH_RECV) ? OP_SEND_REPLY : OP_RECV_REPLY);
         2: b = rand_beat($urandom_range(0, 1) ? OP_WRITE : OP_READ);
         default: b = rand_beat(3'(OP_SPARE_MIN + $urandom_range(0, 2)));
      endcase
      push_beat(b);
   endfunction

   function automatic void finish_transfer(int nack_pct, int noise_pct);
      while (xfer_phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) busy_noise();
         else answer($urandom_range(0, 99) >= nack_pct);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      req_beat_t nb;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_beats.size() == 0 ||
                      (pending_beats[0].drain_first &&
                       (due_count != 0 || (req_chan.valid && req_chan.ready)))) begin
            req_chan.valid <= 1'b0;
         end else begin
            nb = pending_beats.pop_front();
            req_chan.opcode     <= nb.opcode;
            req_chan.device     <= nb.device;
            req_chan.address    <= nb.address;
            req_chan.count      <= nb.count;
            req_chan.data_byte  <= nb.data_byte;
            req_chan.load_index <= nb.load_index;
            req_chan.acked      <= nb.acked;
            req_chan.valid      <= 1'b1;
            beats_sent <= beats_sent + 1;
            quiet      <= (beats_sent + 1 >= quiet_from);
            if (!quiet && $urandom_range(0, 5) == 0) begin
               gap_left <= $urandom_range(1, 13);
            end
         end
      end
   end

   // long receiver hold-off, once, to back the sequencer up
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && results_taken >= HOLD_AFTER) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_beat_t b;
      bus_op_t   want;
      int        added;
      int        removed;
      added   = 0;
      removed = 0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_taken <= results_taken + 1;
            if (bus_ops_due.size() == 0) begin
               flag_error($sformatf("unexpected result beat action %0d byte %0h",
                                    rsp_chan.action, rsp_chan.bus_byte));
            end else begin
               want = bus_ops_due.pop_front();
               removed = 1;
               if (rsp_chan.action !== want.action)
                  flag_error($sformatf("action %0d, expected %0d",
                                       rsp_chan.action, want.action));
               if (rsp_chan.bus_byte !== want.bus_byte)
                  flag_error($sformatf("bus_byte %0h, expected %0h",
                                       rsp_chan.bus_byte, want.bus_byte));
               if (rsp_chan.read_index !== want.read_index)
                  flag_error($sformatf("read_index %0d, expected %0d",
                                       rsp_chan.read_index, want.read_index));
               if (rsp_chan.last !== want.last)
                  flag_error($sformatf("last %0b, expected %0b",
                                       rsp_chan.last, want.last));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            b.opcode     = req_chan.opcode;
            b.device     = req_chan.device;
            b.address    = req_chan.address;
            b.count      = req_chan.count;
            b.data_byte  = req_chan.data_byte;
            b.load_index = req_chan.load_index;
            b.acked      = req_chan.acked;
            added = sequence_bus_ops(b);
            beats_taken <= beats_taken + 1;
         end
         due_count <= due_count + added - removed;
      end
   end

   initial begin
      #5ms;
      $display("tb: errors");
      $finish;
   end

   initial begin
      int  start_useful;
      bit  mid_pause_done;
      bit  wr;
      logic [7:0] cnt;

      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_LOAD;
      req_chan.device     = 3'd0;
      req_chan.address    = 8'd0;
      req_chan.count      = 8'd0;
      req_chan.data_byte  = 8'd0;
      req_chan.load_index = 8'd0;
      req_chan.acked      = 1'b0;
      rsp_chan.ready      = 1'b0;
      errors        = 0;
      gap_left      = 0;
      due_count     = 0;
      beats_taken   = 0;
      results_taken = 0;
      beats_sent    = 0;
      quiet         = 1'b0;
      useful_beats  = 0;
      pause_next    = 1'b0;
      mid_pause_done = 1'b0;
      seq_reset();

      // replies while idle and spare opcodes: all dropped
      push_beat(rand_beat(OP_RECV_REPLY));
      push_beat(rand_beat(OP_SEND_REPLY));
      for (int k = 0; k < 3; k++) push_beat(rand_beat(3'(OP_SPARE_MIN + k)));
      load_byte(8'd0, 8'hFF);
      load_byte(8'd1, 8'h00);
      load_byte(8'd255, 8'h5A);

      // two-byte write at the top of device 7: wraps to device 0
      issue_request(1'b1, 3'd7, 8'hFF, 8'd2);
      answer(1'b1);
      load_byte(8'd1, 8'hA5);
      push_beat(rand_beat(OP_READ));
      answer(1'b0);
      answer(1'b1);
      answer(1'b1);
      answer(1'b1);
      answer(1'b1);
      answer(1'b1);
      answer(1'b0);
      finish_transfer(0, 0);

      // empty read: addressing only
      issue_request(1'b0, 3'd0, 8'h00, 8'd0);
      finish_transfer(0, 0);

      // one multi-page read, drained before the random part starts
      issue_request(1'b0, 3'd7, 8'($urandom), 8'd20);
      finish_transfer(5, 3);
      pause_next = 1'b1;

      start_useful = useful_beats;
      while (useful_beats < start_useful + RANDOM_BEATS) begin
         if (!mid_pause_done && useful_beats >= start_useful + RANDOM_BEATS / 2) begin
            pause_next = 1'b1;
            mid_pause_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0: load_byte(8'($urandom), 8'($urandom));
            1: begin
               case ($urandom_range(0, 2))
                  0: push_beat(rand_beat(OP_RECV_REPLY));
                  1: push_beat(rand_beat(OP_SEND_REPLY));
                  default: push_beat(rand_beat(3'(OP_SPARE_MIN + $urandom_range(0, 2))));
               endcase
            end
            default: begin
               wr  = 1'($urandom);
               cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 40))
                                                 : 8'($urandom_range(0, 12));
               issue_request(wr, 3'($urandom), 8'($urandom), cnt);
               finish_transfer(12, 8);
            end
         endcase
      end

      beat_total = pending_beats.size();
      quiet_from = beat_total * 85 / 100;
      seq_reset();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken != beat_total || due_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
